[src/bsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants
// Phase codes, calibration register indexes, controller states and the
// command/status words between the sequencer and the compensation datapath.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int COEF_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int RAW_W    = 24;
  localparam int TEMP_W   = 19;
  localparam int PRESS_W  = 32;

  // conversion phases
  localparam logic [1:0] PH_START_T = 2'd0;
  localparam logic [1:0] PH_READ_T  = 2'd1;
  localparam logic [1:0] PH_START_P = 2'd2;
  localparam logic [1:0] PH_READ_P  = 2'd3;

  // suggested pauses in ms
  localparam logic [3:0] WAIT_NORMAL = 4'd12;
  localparam logic [3:0] WAIT_CYCLE  = 4'd15;

  // pressure window for the range flag
  localparam logic [PRESS_W-1:0] LOW_PRESS   = 32'd1000;
  localparam logic [PRESS_W-1:0] HIGH_PRESS  = 32'd120000;
  localparam logic [PRESS_W-1:0] RESET_PRESS = 32'd101325;

  // base temperature in 0.01 degC
  localparam logic signed [19:0] TEMP_BASE = 20'sd2000;

  // calibration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_C1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_C3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_C4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_C5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_C6 = 3'd5;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_STEP,
    CS_DT,
    CS_MUL_OFF,
    CS_MUL_SENS,
    CS_MUL_TEMP,
    CS_MUL_PLO,
    CS_MUL_PHI,
    CS_ACC_FULL,
    CS_FINAL,
    CS_DONE
  } ctl_state_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MS_DT_C4,
    MS_DT_C3,
    MS_DT_C6,
    MS_RAW_LO,
    MS_RAW_HI
  } mul_sel_t;

  // what to do with the product registered in the previous cycle
  typedef enum logic [2:0] {
    AS_NONE,
    AS_OFF,
    AS_SENS,
    AS_TEMP,
    AS_PLO,
    AS_FULL,
    AS_PRESS
  } acc_sel_t;

  typedef struct packed {
    logic     in_load;
    logic     step_en;
    logic     dt_en;
    mul_sel_t mul_sel;
    acc_sel_t acc_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic comp;
  } dp_stat_t;

endpackage
`default_nettype wire

[src/bsc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_ctrl: sequencing controller
// Accepts one word at a time, steps the phase, walks the compensation
// schedule on a successful pressure read and hands the result to the output.
// ----------------------------------------------------------------------------
module bsc_ctrl
  import bsc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctl_state_t state, state_next;
  logic       out_valid_next;

  // state and output flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mul_sel  = MS_DT_C4;
    cmd.acc_sel  = AS_NONE;
    in_ready     = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      CS_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = in_valid;
        if (in_valid) begin
          state_next = CS_STEP;
        end
      end
      CS_STEP: begin
        cmd.step_en = 1'b1;
        state_next  = stat.comp ? CS_DT : CS_DONE;
      end
      CS_DT: begin
        cmd.dt_en  = 1'b1;
        state_next = CS_MUL_OFF;
      end
      CS_MUL_OFF: begin
        cmd.mul_sel = MS_DT_C4;
        state_next  = CS_MUL_SENS;
      end
      CS_MUL_SENS: begin
        cmd.mul_sel = MS_DT_C3;
        cmd.acc_sel = AS_OFF;
        state_next  = CS_MUL_TEMP;
      end
      CS_MUL_TEMP: begin
        cmd.mul_sel = MS_DT_C6;
        cmd.acc_sel = AS_SENS;
        state_next  = CS_MUL_PLO;
      end
      CS_MUL_PLO: begin
        cmd.mul_sel = MS_RAW_LO;
        cmd.acc_sel = AS_TEMP;
        state_next  = CS_MUL_PHI;
      end
      CS_MUL_PHI: begin
        cmd.mul_sel = MS_RAW_HI;
        cmd.acc_sel = AS_PLO;
        state_next  = CS_ACC_FULL;
      end
      CS_ACC_FULL: begin
        cmd.acc_sel = AS_FULL;
        state_next  = CS_FINAL;
      end
      CS_FINAL: begin
        cmd.acc_sel = AS_PRESS;
        state_next  = CS_DONE;
      end
      CS_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/bsc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_datapath: phase state, calibration words and compensation arithmetic
// One shared 26x18 signed multiplier with a product register; the wide
// raw-pressure product is built from two partial products.
// ----------------------------------------------------------------------------
module bsc_datapath
  import bsc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data,
  input  wire logic                 step_ok,
  input  wire logic [RAW_W-1:0]     read_value,
  output logic [1:0]                next_phase,
  output logic [3:0]                wait_ms,
  output logic                      result_new,
  output logic [PRESS_W-1:0]        pressure_pa,
  output logic signed [TEMP_W-1:0]  temp_centi_c,
  output logic                      pressure_in_range
);

  logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6;
  logic [1:0]        phase;
  logic [RAW_W-1:0]  raw_temp;
  logic [PRESS_W-1:0] last_pressure;
  logic signed [TEMP_W-1:0] last_temp;

  logic              ok_q;
  logic [RAW_W-1:0]  val_q;
  logic [3:0]        wait_q;
  logic              fresh_q;

  logic signed [24:0] dt;
  logic signed [25:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [43:0] prod;
  logic signed [35:0] off;
  logic signed [33:0] sens;
  logic [40:0]        plo;
  logic signed [58:0] full;
  logic signed [19:0] temp_sum;
  logic signed [38:0] press_diff;
  logic signed [38:0] press_shr;

  assign stat.comp = (phase == PH_READ_P) && ok_q;

  // calibration word writes
  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_C1:  c1 <= cfg_data;
        CFG_C2:  c2 <= cfg_data;
        CFG_C3:  c3 <= cfg_data;
        CFG_C4:  c4 <= cfg_data;
        CFG_C5:  c5 <= cfg_data;
        CFG_C6:  c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      ok_q  <= step_ok;
      val_q <= read_value;
    end
  end

  // advance the phase; drop back on failure
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START_T;
      raw_temp <= '0;
    end else if (cmd.step_en) begin
      case (phase)
        PH_START_T: phase <= ok_q ? PH_READ_T : PH_START_T;
        PH_READ_T: begin
          if (ok_q) begin
            raw_temp <= val_q;
            phase    <= PH_START_P;
          end else begin
            phase <= PH_START_T;
          end
        end
        PH_START_P: phase <= ok_q ? PH_READ_P : PH_START_P;
        PH_READ_P:  phase <= ok_q ? PH_START_T : PH_START_P;
        default:    phase <= PH_START_T;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_en) begin
      fresh_q <= stat.comp;
      wait_q  <= stat.comp ? WAIT_CYCLE : WAIT_NORMAL;
    end
  end

  // temperature difference against the reference
  always_ff @(posedge clk) begin
    if (cmd.dt_en) begin
      dt <= $signed({1'b0, raw_temp}) - $signed({1'b0, c5, 8'h00});
    end
  end

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MS_DT_C4: begin
        mul_a = {dt[24], dt};
        mul_b = $signed({2'b00, c4});
      end
      MS_DT_C3: begin
        mul_a = {dt[24], dt};
        mul_b = $signed({2'b00, c3});
      end
      MS_DT_C6: begin
        mul_a = {dt[24], dt};
        mul_b = $signed({2'b00, c6});
      end
      MS_RAW_LO: begin
        mul_a = $signed({2'b00, val_q});
        mul_b = $signed({1'b0, sens[16:0]});
      end
      MS_RAW_HI: begin
        mul_a = $signed({2'b00, val_q});
        mul_b = {sens[33], sens[33:17]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign temp_sum   = 20'(prod >>> 23) + TEMP_BASE;
  assign press_diff = 39'(full >>> 21) - 39'(off);
  assign press_shr  = press_diff >>> 15;

  // accumulate partial results
  always_ff @(posedge clk) begin
    case (cmd.acc_sel)
      AS_OFF:  off  <= $signed({4'b0000, c2, 16'h0000}) + 36'(prod >>> 7);
      AS_SENS: sens <= $signed({3'b000, c1, 15'h0000}) + 34'(prod >>> 8);
      AS_PLO:  plo  <= prod[40:0];
      AS_FULL: full <= (59'(prod) <<< 17) + $signed({18'b0, plo});
      default: ;
    endcase
  end

  // keep the latest compensated values
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressure <= RESET_PRESS;
      last_temp     <= '0;
    end else begin
      if (cmd.acc_sel == AS_TEMP) begin
        last_temp <= temp_sum[TEMP_W-1:0];
      end
      if (cmd.acc_sel == AS_PRESS) begin
        last_pressure <= press_shr[PRESS_W-1:0];
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      next_phase        <= phase;
      wait_ms           <= wait_q;
      result_new        <= fresh_q;
      pressure_pa       <= last_pressure;
      temp_centi_c      <= last_temp;
      pressure_in_range <= (last_pressure >= LOW_PRESS) && (last_pressure <= HIGH_PRESS);
    end
  end

endmodule
`default_nettype wire

[src/baro_sequence_and_compensation_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baro_sequence_and_compensation_top: barometer phase sequencer and
// first-order pressure/temperature compensation
//
// Input channel (in_valid/in_ready) carries one word per bus step: step_ok
// and the 24-bit raw reading. Each accepted word yields exactly one output
// word (out_valid/out_ready): next phase, suggested wait, fresh flag, last
// pressure, last temperature and the pressure range flag.
// Calibration words are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Indexes above 5 are ignored. A plain step runs from accept to
// output through the step and done states; a successful pressure read adds
// the dt state, five passes through the single shared 26x18 multiplier and
// the final add and shift stages. One word is in work at a time, so the input
// accepts again in the cycle after the output loads.
// A finished word waits in the output register while the receiver stalls;
// the next word is still accepted and worked on, then holds until the
// output register frees up.
// Reset clears the phase, raw temperature, temperature and calibration
// words, sets the stored pressure to 101325 Pa and empties the output.
// ----------------------------------------------------------------------------
module baro_sequence_and_compensation_top
  import bsc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 step_ok,
  input  wire logic [RAW_W-1:0]     read_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                next_phase,
  output logic [3:0]                wait_ms,
  output logic                      result_new,
  output logic [PRESS_W-1:0]        pressure_pa,
  output logic signed [TEMP_W-1:0]  temp_centi_c,
  output logic                      pressure_in_range,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bsc_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .step_ok           (step_ok),
    .read_value        (read_value),
    .next_phase        (next_phase),
    .wait_ms           (wait_ms),
    .result_new        (result_new),
    .pressure_pa       (pressure_pa),
    .temp_centi_c      (temp_centi_c),
    .pressure_in_range (pressure_in_range)
  );

  // a fresh result always closes a full cycle
  a_fresh_cycle : assert property (@(posedge clk) disable iff (rst)
    out_valid && result_new |-> (next_phase == PH_START_T) && (wait_ms == WAIT_CYCLE))
    else $error("fresh result without cycle wrap");

  // plain steps use the normal wait
  a_plain_wait : assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_new |-> wait_ms == WAIT_NORMAL)
    else $error("wrong wait on plain step");

  // range flag agrees with the pressure shown
  a_range_flag : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pressure_in_range ==
      ((pressure_pa >= LOW_PRESS) && (pressure_pa <= HIGH_PRESS)))
    else $error("range flag mismatch");

  // one word in work at a time
  a_one_in_work : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: barometer sequencer and compensation testbench
// Walks a short table of directed steps, then random conversion cycles under
// several calibration sets. Each accepted input word is predicted in
// 64-bit signed arithmetic, and every output word is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import bsc_pkg::*;

  localparam int LIMIT = 500000;
  localparam int SETTLE = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [1:0]         ph;
    logic [3:0]         wt;
    logic               fresh;
    logic [PRESS_W-1:0] press;
    logic [TEMP_W-1:0]  temp;
    logic               rng;
  } baro_word_t;

  typedef enum logic [1:0] {ROW_LIT, ROW_STEP, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    bit                   ok;
    logic [RAW_W-1:0]     val;
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    data;
    baro_word_t           want;
  } stim_row_t;

  typedef enum logic [1:0] {CAL_TYPICAL, CAL_RANDOM, CAL_MAX, CAL_ZERO} cal_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic step_ok = 1'b0;
  logic [RAW_W-1:0] read_value = '0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  logic in_ready;
  logic out_valid;
  logic [1:0] next_phase;
  logic [3:0] wait_ms;
  logic result_new;
  logic [PRESS_W-1:0] pressure_pa;
  logic signed [TEMP_W-1:0] temp_centi_c;
  logic pressure_in_range;

  // predicted block state
  logic [1:0]         seq_phase = PH_START_T;
  logic [RAW_W-1:0]   seq_raw_t = '0;
  logic [PRESS_W-1:0] seq_press = RESET_PRESS;
  logic [TEMP_W-1:0]  seq_temp = '0;
  logic [COEF_W-1:0]  cal_coef [6] = '{default: '0};

  baro_word_t due_words [$];
  baro_word_t offered_word = '0;
  stim_row_t  plan [$];
  int         fault_cnt = 0;
  int         cycle_cnt = 0;
  bit         no_stall = 1'b0;
  int         stall_left = 0;

  always #1 clk = ~clk;

  baro_sequence_and_compensation_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .step_ok(step_ok),
    .read_value(read_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .next_phase(next_phase),
    .wait_ms(wait_ms),
    .result_new(result_new),
    .pressure_pa(pressure_pa),
    .temp_centi_c(temp_centi_c),
    .pressure_in_range(pressure_in_range),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // first-order compensation of a raw pressure reading
  function automatic void compensate_reading(input logic [RAW_W-1:0] raw_p);
    longint dt, off, sens, p, t;
    dt = longint'(seq_raw_t) - (longint'(cal_coef[4]) <<< 8);
    off = (longint'(cal_coef[1]) <<< 16) + ((dt * longint'(cal_coef[3])) >>> 7);
    sens = (longint'(cal_coef[0]) <<< 15) + ((dt * longint'(cal_coef[2])) >>> 8);
    p = (((longint'(raw_p) * sens) >>> 21) - off) >>> 15;
    t = longint'(TEMP_BASE) + ((dt * longint'(cal_coef[5])) >>> 23);
    seq_press = p[PRESS_W-1:0];
    seq_temp = t[TEMP_W-1:0];
  endfunction

  // advance the phase sequencer by one step and form the output word
  function automatic baro_word_t advance_sequencer(input bit ok, input logic [RAW_W-1:0] val);
    baro_word_t w;
    w.wt = WAIT_NORMAL;
    w.fresh = 1'b0;
    case (seq_phase)
      PH_START_T: seq_phase = ok ? PH_READ_T : PH_START_T;
      PH_READ_T: begin
        if (ok) begin
          seq_raw_t = val;
          seq_phase = PH_START_P;
        end else begin
          seq_phase = PH_START_T;
        end
      end
      PH_START_P: seq_phase = ok ? PH_READ_P : PH_START_P;
      default: begin
        if (ok) begin
          compensate_reading(val);
          seq_phase = PH_START_T;
          w.wt = WAIT_CYCLE;
          w.fresh = 1'b1;
        end else begin
          seq_phase = PH_START_P;
        end
      end
    endcase
    w.ph = seq_phase;
    w.press = seq_press;
    w.temp = seq_temp;
    w.rng = (seq_press >= LOW_PRESS) && (seq_press <= HIGH_PRESS);
    return w;
  endfunction

  function automatic logic [COEF_W-1:0] nominal_coef(input int k);
    case (k)
      0: return 16'd40127;
      1: return 16'd36924;
      2: return 16'd23317;
      3: return 16'd23282;
      4: return 16'd33464;
      default: return 16'd28312;
    endcase
  endfunction

  // table builders
  function automatic void add_lit(input bit ok, input logic [RAW_W-1:0] val,
                                  input logic [1:0] ph, input logic [3:0] wt,
                                  input logic fresh, input logic [PRESS_W-1:0] press,
                                  input logic [TEMP_W-1:0] temp, input logic rng);
    stim_row_t r;
    r.kind = ROW_LIT;
    r.ok = ok;
    r.val = val;
    r.idx = '0;
    r.data = '0;
    r.want = {ph, wt, fresh, press, temp, rng};
    plan.push_back(r);
  endfunction

  function automatic void add_step(input bit ok, input logic [RAW_W-1:0] val);
    stim_row_t r;
    r.kind = ROW_STEP;
    r.ok = ok;
    r.val = val;
    r.idx = '0;
    r.data = '0;
    r.want = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.ok = 1'b0;
    r.val = '0;
    r.idx = idx;
    r.data = data;
    r.want = '0;
    plan.push_back(r);
  endfunction

  // wait until every accepted word has come back
  task automatic wait_drain();
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
  endtask

  // write one calibration register; lower the enable after the last of a batch
  task automatic set_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data,
                          input bit last);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx <= CFG_C6) cal_coef[idx] = data;
    if (last) cfg_we <= 1'b0;
  endtask

  // random gap before the next input word
  task automatic sender_gap();
    int n;
    n = 0;
    if (!no_stall) begin
      if ($urandom_range(99) < 3) n = $urandom_range(30, 4);
      else while ($urandom_range(99) < 16) n++;
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // offer one word and hold it until accepted
  task automatic send_word(input bit ok, input logic [RAW_W-1:0] val, input baro_word_t w);
    sender_gap();
    in_valid <= 1'b1;
    step_ok <= ok;
    read_value <= val;
    offered_word <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [RAW_W-1:0] pick_reading(input cal_kind_t kind);
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (kind == CAL_TYPICAL) return 24'($urandom_range(9600000, 7800000));
    return 24'($urandom());
  endfunction

  // one calibration set followed by random conversion cycles
  task automatic run_phase(input cal_kind_t kind, input int n_items, input bit calm);
    logic [COEF_W-1:0] c;
    logic [RAW_W-1:0] val;
    bit ok;
    baro_word_t w;
    in_valid <= 1'b0;
    wait_drain();
    repeat (12) @(posedge clk);
    no_stall <= calm;
    if ($urandom_range(1)) begin
      set_coef($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom()), 1'b0);
    end
    for (int k = 0; k < 6; k++) begin
      case (kind)
        CAL_TYPICAL: c = nominal_coef(k) + 16'($urandom_range(3000)) - 16'd1500;
        CAL_RANDOM:  c = 16'($urandom());
        CAL_MAX:     c = '1;
        default:     c = '0;
      endcase
      set_coef(CFG_C1 + 3'(k), c, k == 5);
    end
    for (int i = 0; i < n_items; i++) begin
      ok = $urandom_range(99) < 88;
      val = pick_reading(kind);
      w = advance_sequencer(ok, val);
      send_word(ok, val, w);
      // hold off until the block has emptied
      if (i == n_items / 2) begin
        in_valid <= 1'b0;
        wait_drain();
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fault_cnt++;
      if (fault_cnt <= 10) $display("mismatch %s: expected %h got %h", name, want, got);
    end
  endtask

  // receiver: random ready with rare long stalls
  always @(posedge clk) begin
    if (no_stall) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(999) < 5) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(30, 5);
    end else begin
      out_ready <= $urandom_range(99) >= 10;
    end
  end

  // check output words against the oldest prediction, then log accepted inputs
  always @(posedge clk) begin : watch
    baro_word_t w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= 10) $display("output word with nothing expected");
        end else begin
          w = due_words.pop_front();
          check_field("next_phase", 32'(w.ph), 32'(next_phase));
          check_field("wait_ms", 32'(w.wt), 32'(wait_ms));
          check_field("result_new", 32'(w.fresh), 32'(result_new));
          check_field("pressure_pa", w.press, pressure_pa);
          check_field("temp_centi_c", 32'(w.temp), 32'($unsigned(temp_centi_c)));
          check_field("pressure_in_range", 32'(w.rng), 32'(pressure_in_range));
        end
      end
      if (in_valid && in_ready) due_words.push_back(offered_word);
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main
    baro_word_t w;
    cal_kind_t phase_plan [6];
    bit last;
    phase_plan = '{CAL_TYPICAL, CAL_RANDOM, CAL_MAX, CAL_TYPICAL, CAL_ZERO, CAL_RANDOM};

    // reset calibration: pressure folds to zero, temperature to the base value
    add_lit(1'b0, 24'h000000, PH_START_T, WAIT_NORMAL, 1'b0, RESET_PRESS, '0, 1'b1);
    add_lit(1'b1, 24'h000000, PH_READ_T, WAIT_NORMAL, 1'b0, RESET_PRESS, '0, 1'b1);
    add_lit(1'b0, 24'hFFFFFF, PH_START_T, WAIT_NORMAL, 1'b0, RESET_PRESS, '0, 1'b1);
    add_lit(1'b1, 24'h000000, PH_READ_T, WAIT_NORMAL, 1'b0, RESET_PRESS, '0, 1'b1);
    add_lit(1'b1, 24'hFFFFFF, PH_START_P, WAIT_NORMAL, 1'b0, RESET_PRESS, '0, 1'b1);
    add_lit(1'b0, 24'h000000, PH_START_P, WAIT_NORMAL, 1'b0, RESET_PRESS, '0, 1'b1);
    add_lit(1'b1, 24'h000000, PH_READ_P, WAIT_NORMAL, 1'b0, RESET_PRESS, '0, 1'b1);
    add_lit(1'b0, 24'hFFFFFF, PH_START_P, WAIT_NORMAL, 1'b0, RESET_PRESS, '0, 1'b1);
    add_lit(1'b1, 24'h000000, PH_READ_P, WAIT_NORMAL, 1'b0, RESET_PRESS, '0, 1'b1);
    add_lit(1'b1, 24'hFFFFFF, PH_START_T, WAIT_CYCLE, 1'b1, '0, 19'd2000, 1'b0);

    // nominal calibration; spare indexes must not disturb it
    for (int k = 0; k < 6; k++) add_cfg(CFG_C1 + 3'(k), nominal_coef(k));
    add_cfg(CFG_SPARE_LO, 16'hFFFF);
    add_cfg(CFG_SPARE_HI, 16'h0000);
    add_step(1'b1, 24'h000000);
    add_step(1'b1, 24'd8569150);
    add_step(1'b1, 24'h000000);
    add_step(1'b1, 24'd9085466);

    // extreme calibration: full-scale temperature with zero pressure goes negative
    add_cfg(CFG_C1, 16'h0000);
    for (int k = 1; k < 6; k++) add_cfg(CFG_C1 + 3'(k), 16'hFFFF);
    add_step(1'b1, 24'h000000);
    add_step(1'b1, 24'hFFFFFF);
    add_step(1'b1, 24'h000000);
    add_step(1'b1, 24'h000000);
    add_step(1'b1, 24'hFFFFFF);
    add_step(1'b1, 24'h000000);
    add_step(1'b1, 24'h5A5A5A);
    add_step(1'b1, 24'hFFFFFF);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    for (int i = 0; i < plan.size(); i++) begin
      case (plan[i].kind)
        ROW_CFG: begin
          if (i == 0 || plan[i-1].kind != ROW_CFG) begin
            in_valid <= 1'b0;
            wait_drain();
            repeat (12) @(posedge clk);
          end
          last = (i + 1 == plan.size()) || (plan[i+1].kind != ROW_CFG);
          set_coef(plan[i].idx, plan[i].data, last);
        end
        ROW_LIT: begin
          w = advance_sequencer(plan[i].ok, plan[i].val);
          send_word(plan[i].ok, plan[i].val, plan[i].want);
        end
        default: begin
          w = advance_sequencer(plan[i].ok, plan[i].val);
          send_word(plan[i].ok, plan[i].val, w);
        end
      endcase
    end

    // random cycles; the fourth set runs with no idling on either side
    for (int p = 0; p < 6; p++) run_phase(phase_plan[p], 100, p == 3);

    in_valid <= 1'b0;
    no_stall <= 1'b0;
    wait_drain();
    repeat (SETTLE) @(posedge clk);
    if (fault_cnt == 0 && due_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
